### design/dis_pkg.sv
// Package: shared types, constants and opcodes for the disjoint interval set.
package dis_pkg;

  localparam int MaxRanges = 16;
  localparam int ValueBits = 32;
  localparam int IdxBits = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;
  localparam int CntBits = $clog2(MaxRanges + 1);

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_MEMBER = 3'd2;
  localparam logic [2:0] OP_NEXT = 3'd3;
  localparam logic [2:0] OP_PREV = 3'd4;
  localparam logic [2:0] OP_PREVMISS = 3'd5;
  localparam logic [2:0] OP_FIRST = 3'd6;
  localparam logic [2:0] OP_LAST = 3'd7;

  typedef logic [ValueBits-1:0] val_t;
  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;

  typedef struct packed {
    logic [2:0] op;
    logic [31:0] value;
    logic [31:0] range_end;
  } in_req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic found;
    logic table_full;
  } out_req_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, reset scan
    logic scan;      // evaluate entry at scan index, advance
    logic decide;    // finalize scan results, plan edit
    logic edit;      // do one shift step or the planned writes
    logic finish;    // form result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic edit_done;
  } dp_sts_t;

endpackage

### design/dis_ctrl.sv
// Controller: sequences load, scan, decide, edit and result phases.
module dis_ctrl
  import dis_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC = 3'd2;
  localparam logic [2:0] S_EDIT = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // accept a new request only when idle and the result slot is free
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        state_nxt = S_EDIT;
      end
      S_EDIT: begin
        cmd.edit = 1'b1;
        if (sts.edit_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!(out_valid_r && out_stall)) begin
          cmd.finish = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/dis_dp.sv
// Datapath: range table, sequential scan and shift-based editing.
module dis_dp
  import dis_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dp_cmd_t  cmd,
  input  in_req_t  in_data,
  output dp_sts_t  sts,
  output out_req_t out_data
);

  val_t lo_r [MaxRanges];
  val_t hi_r [MaxRanges];
  cnt_t count_r;

  logic [2:0] op_r;
  val_t v_r, e_r;
  cnt_t idx_r;
  // scan findings
  logic have_i_r, have_j_r, have_mem_r, have_nx_r, have_pv_r, have_pm_r;
  cnt_t i_r, j_r, mem_r;
  val_t nx_r, pv_r, pm_lo_r;
  // edit plan
  logic full_r;
  logic shl_r, shr_r;   // shift left (remove) or right (insert)
  cnt_t pos_r, steps_r, dist_r;
  val_t wlo_r, whi_r, wlo2_r, whi2_r;
  logic wr_r, wr2_r;
  cnt_t wpos_r;
  out_req_t out_r;
  out_req_t out_c;

  idx_t ix;
  val_t lo_c, hi_c;
  logic in_rng;

  assign ix = idx_r[IdxBits-1:0];
  assign lo_c = lo_r[ix];
  assign hi_c = hi_r[ix];
  assign in_rng = (v_r >= lo_c) && (v_r <= hi_c);
  assign sts.scan_done = (idx_r >= count_r) || (count_r == '0) ||
                         (idx_r == cnt_t'(MaxRanges - 1));
  assign sts.edit_done = (steps_r == '0);
  assign out_data = out_r;

  function automatic logic touches(val_t a_hi, val_t b_lo);
    return (a_hi >= b_lo) || ((b_lo != '0) && (a_hi == b_lo - val_t'(1)));
  endfunction

  // decide-phase combinational plan
  logic full_c, shl_c, shr_c, wr_c, wr2_c;
  cnt_t pos_c, steps_c, wpos_c, jn, dist_c;
  val_t wlo_c, whi_c, wlo2_c, whi2_c, mlo, mhi, pm_c;
  logic pm_f;
  idx_t mi, ii, jm;

  always_comb begin
    full_c = 1'b0; shl_c = 1'b0; shr_c = 1'b0; wr_c = 1'b0; wr2_c = 1'b0;
    pos_c = '0; steps_c = '0; wpos_c = '0; wlo_c = '0; whi_c = '0;
    wlo2_c = '0; whi2_c = '0; dist_c = '0;
    jn = have_j_r ? j_r : count_r;
    mi = mem_r[IdxBits-1:0];
    ii = i_r[IdxBits-1:0];
    jm = IdxBits'(jn - cnt_t'(1));
    mlo = lo_r[mi];
    mhi = hi_r[mi];
    pm_f = 1'b0; pm_c = '0;
    unique case (op_r)
      OP_INSERT: begin
        if (v_r <= e_r) begin
          if (!have_i_r || jn == i_r) begin
            if (count_r >= cnt_t'(MaxRanges)) full_c = 1'b1;
            else begin
              shr_c = 1'b1; pos_c = have_i_r ? i_r : count_r;
              steps_c = count_r - pos_c;
              wr_c = 1'b1; wpos_c = pos_c; wlo_c = v_r; whi_c = e_r;
            end
          end else begin
            // merge into entry i and close the gap of the absorbed entries
            wr_c = 1'b1; wpos_c = i_r;
            wlo_c = (lo_r[ii] < v_r) ? lo_r[ii] : v_r;
            whi_c = (hi_r[jm] > e_r) ? hi_r[jm] : e_r;
            dist_c = jn - i_r - cnt_t'(1);
            shl_c = (dist_c != '0); pos_c = i_r + cnt_t'(1);
            steps_c = shl_c ? (count_r - jn) : '0;
          end
        end
      end
      OP_CLEAR: begin
        if (have_mem_r) begin
          if (mlo == v_r && mhi == v_r) begin
            shl_c = 1'b1; pos_c = mem_r; dist_c = cnt_t'(1);
            steps_c = count_r - mem_r - cnt_t'(1);
          end else if (mlo == v_r) begin
            wr_c = 1'b1; wpos_c = mem_r; wlo_c = v_r + val_t'(1); whi_c = mhi;
          end else if (mhi == v_r) begin
            wr_c = 1'b1; wpos_c = mem_r; wlo_c = mlo; whi_c = v_r - val_t'(1);
          end else if (count_r >= cnt_t'(MaxRanges)) begin
            full_c = 1'b1;
          end else begin
            // split: open a slot after the entry, shorten it, fill the slot
            shr_c = 1'b1; pos_c = mem_r + cnt_t'(1);
            steps_c = count_r - pos_c;
            wr_c = 1'b1; wpos_c = mem_r; wlo_c = mlo; whi_c = v_r - val_t'(1);
            wr2_c = 1'b1; wlo2_c = v_r + val_t'(1); whi2_c = mhi;
          end
        end
      end
      default: begin
      end
    endcase
    // largest non-member below v: step below the range holding v - 1
    if (v_r != '0) begin
      pm_f = 1'b1; pm_c = v_r - val_t'(1);
      if (have_pm_r) begin
        if (pm_lo_r == '0) pm_f = 1'b0;
        else pm_c = pm_lo_r - val_t'(1);
      end
    end
  end

  // shift step: move one entry per cycle
  idx_t sa, sb;
  assign sa = pos_r[IdxBits-1:0];
  assign sb = IdxBits'(pos_r + steps_r - cnt_t'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      if (cmd.decide) begin
        if (shl_c) count_r <= count_r - dist_c;
        else if (shr_c) count_r <= count_r + cnt_t'(1);
      end
    end
  end

  // form the result from the scan and plan findings
  always_comb begin
    out_c = '0;
    out_c.table_full = full_r;
    unique case (op_r)
      OP_MEMBER: out_c.found = have_mem_r;
      OP_NEXT: begin out_c.found = have_nx_r; out_c.result_value = nx_r; end
      OP_PREV: begin out_c.found = have_pv_r; out_c.result_value = pv_r; end
      OP_PREVMISS: begin
        out_c.found = have_nx_r;
        out_c.result_value = have_nx_r ? nx_r : '0;
      end
      OP_FIRST: begin
        out_c.found = (count_r != '0);
        out_c.result_value = (count_r != '0) ? lo_r[0] : '0;
      end
      OP_LAST: begin
        out_c.found = (count_r != '0);
        out_c.result_value = (count_r != '0) ?
          hi_r[IdxBits'(count_r - cnt_t'(1))] : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_data.op; v_r <= in_data.value; e_r <= in_data.range_end;
      idx_r <= '0;
      have_i_r <= 1'b0; have_j_r <= 1'b0; have_mem_r <= 1'b0;
      have_nx_r <= 1'b0; have_pv_r <= 1'b0; have_pm_r <= 1'b0;
      i_r <= '0; j_r <= '0; mem_r <= '0; nx_r <= '0; pv_r <= '0; pm_lo_r <= '0;
    end
    // scan one entry per cycle, forward
    if (cmd.scan && idx_r < count_r) begin
      if (!have_i_r && touches(hi_c, v_r)) begin
        have_i_r <= 1'b1; i_r <= idx_r;
      end
      if (!have_j_r && (have_i_r || touches(hi_c, v_r)) && !touches(e_r, lo_c)) begin
        have_j_r <= 1'b1; j_r <= idx_r;
      end
      if (in_rng && !have_mem_r) begin
        have_mem_r <= 1'b1; mem_r <= idx_r;
      end
      if (!have_nx_r) begin
        if (lo_c > v_r) begin have_nx_r <= 1'b1; nx_r <= lo_c; end
        else if (hi_c > v_r) begin have_nx_r <= 1'b1; nx_r <= v_r + val_t'(1); end
      end
      // last entry with lo < v gives the prev answer
      if (hi_c < v_r) begin have_pv_r <= 1'b1; pv_r <= hi_c; end
      else if (lo_c < v_r) begin have_pv_r <= 1'b1; pv_r <= v_r - val_t'(1); end
      // remember the low end of the range holding v - 1
      if ((v_r != '0) && (lo_c < v_r) && (hi_c >= v_r - val_t'(1))) begin
        have_pm_r <= 1'b1; pm_lo_r <= lo_c;
      end
    end
    if (cmd.scan) idx_r <= idx_r + cnt_t'(1);
    if (cmd.decide) begin
      full_r <= full_c; shl_r <= shl_c; shr_r <= shr_c;
      pos_r <= pos_c; steps_r <= steps_c; dist_r <= dist_c;
      wr_r <= wr_c; wpos_r <= wpos_c; wlo_r <= wlo_c; whi_r <= whi_c;
      wr2_r <= wr2_c; wlo2_r <= wlo2_c; whi2_r <= whi2_c;
      // prev missing answer travels in the next slot
      if (op_r == OP_PREVMISS) begin
        nx_r <= pm_c; have_nx_r <= pm_f;
      end
    end
    // shift entries first, then write the planned entries in the last edit cycle
    if (cmd.edit) begin
      if (steps_r != '0) begin
        if (shl_r) begin
          lo_r[sa] <= lo_r[IdxBits'(pos_r + dist_r)];
          hi_r[sa] <= hi_r[IdxBits'(pos_r + dist_r)];
          pos_r <= pos_r + cnt_t'(1);
          steps_r <= steps_r - cnt_t'(1);
        end else if (shr_r) begin
          lo_r[IdxBits'(pos_r + steps_r)] <= lo_r[sb];
          hi_r[IdxBits'(pos_r + steps_r)] <= hi_r[sb];
          steps_r <= steps_r - cnt_t'(1);
        end else begin
          steps_r <= '0;
        end
      end else begin
        if (wr_r) begin
          lo_r[IdxBits'(wpos_r)] <= wlo_r;
          hi_r[IdxBits'(wpos_r)] <= whi_r;
        end
        if (wr2_r) begin
          lo_r[IdxBits'(wpos_r + cnt_t'(1))] <= wlo2_r;
          hi_r[IdxBits'(wpos_r + cnt_t'(1))] <= whi2_r;
        end
      end
    end
    if (cmd.finish) out_r <= out_c;
  end

endmodule

### design/disjoint_interval_set.sv
// Top level: disjoint interval set, controller plus datapath.
//   channel | direction | payload     | handshake
//   in_     | input     | in_req_t    | in_valid / in_stall
//   out_    | output    | out_req_t   | out_valid / out_stall
// From acceptance to result: a scan phase, one entry per cycle, a plan phase, an edit
// phase that shifts one entry per cycle and then writes the planned entries, and a
// result phase; the next request can be taken as the result leaves.
// Reset (rst_n low, synchronous) empties the table; entries are undefined.
// The result register holds while out_stall is high, and in_stall stays high meanwhile.
module disjoint_interval_set
  import dis_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  dis_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  dis_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_data(in_data),
    .sts(sts), .out_data(out_data)
  );

endmodule

### design/dis_checker.sv
// Checker: port-level properties of the disjoint interval set.
module dis_checker
  import dis_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // take no request the cycle after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("back-to-back request taken");

  // a request never yields a result in the next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result too early");

  // a table-full result never reports found
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |-> !out_data.found)
    else $error("full with found");

endmodule

bind disjoint_interval_set dis_checker u_dis_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

### verif/disjoint_interval_set_tb.sv
// Testbench for the disjoint interval set: queued requests, predictor, result checker.
module disjoint_interval_set_tb
  import dis_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_req_t out_data;

  disjoint_interval_set i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the range table
  logic [31:0] lo_tab [MaxRanges];
  logic [31:0] hi_tab [MaxRanges];
  int n_ranges = 0;

  in_req_t pending_reqs[$];
  out_req_t expected_results[$];
  int errors = 0;
  int mismatches = 0;
  bit stim_done = 1'b0;
  bit pause_req = 1'b0;
  int hold_cycles = 0;
  bit in_taken = 1'b0;

  // true when a range ending at a_hi overlaps or abuts one starting at b_lo
  function automatic bit abuts(logic [31:0] a_hi, logic [31:0] b_lo);
    return a_hi >= b_lo || (b_lo != 0 && a_hi == b_lo - 32'd1);
  endfunction

  function automatic void drop_entry(int i);
    for (int k = i; k + 1 < n_ranges; k++) begin
      lo_tab[k] = lo_tab[k+1];
      hi_tab[k] = hi_tab[k+1];
    end
    n_ranges--;
  endfunction

  function automatic void open_entry(int i, logic [31:0] lo, logic [31:0] hi);
    for (int k = n_ranges; k > i; k--) begin
      lo_tab[k] = lo_tab[k-1];
      hi_tab[k] = hi_tab[k-1];
    end
    lo_tab[i] = lo;
    hi_tab[i] = hi;
    n_ranges++;
  endfunction

  // apply one request to the table and form its result
  function automatic out_req_t apply_request(in_req_t r);
    out_req_t res;
    logic [31:0] v, e, lo, hi, c;
    int i, j, cnt;
    res = '0;
    v = r.value;
    e = r.range_end;
    case (r.op)
      OP_INSERT: begin
        if (v <= e) begin
          i = 0;
          while (i < n_ranges && !abuts(hi_tab[i], v)) i++;
          j = i;
          while (j < n_ranges && abuts(e, lo_tab[j])) j++;
          if (j == i) begin
            if (n_ranges >= MaxRanges) res.table_full = 1'b1;
            else open_entry(i, v, e);
          end else begin
            lo = (lo_tab[i] < v) ? lo_tab[i] : v;
            hi = (hi_tab[j-1] > e) ? hi_tab[j-1] : e;
            lo_tab[i] = lo;
            hi_tab[i] = hi;
            cnt = j - i - 1;
            for (int k = 0; k < cnt; k++) drop_entry(i + 1);
          end
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < n_ranges; i++) begin
          lo = lo_tab[i];
          hi = hi_tab[i];
          if (v >= lo && v <= hi) begin
            if (lo == v && hi == v) drop_entry(i);
            else if (lo == v) lo_tab[i] = v + 32'd1;
            else if (hi == v) hi_tab[i] = v - 32'd1;
            else if (n_ranges >= MaxRanges) res.table_full = 1'b1;
            else begin
              hi_tab[i] = v - 32'd1;
              open_entry(i + 1, v + 32'd1, hi);
            end
            break;
          end
        end
      end
      OP_MEMBER: begin
        for (i = 0; i < n_ranges; i++)
          if (v >= lo_tab[i] && v <= hi_tab[i]) res.found = 1'b1;
      end
      OP_NEXT: begin
        for (i = 0; i < n_ranges && !res.found; i++) begin
          if (lo_tab[i] > v) begin
            res.result_value = lo_tab[i];
            res.found = 1'b1;
          end else if (hi_tab[i] > v) begin
            res.result_value = v + 32'd1;
            res.found = 1'b1;
          end
        end
      end
      OP_PREV: begin
        for (i = n_ranges; i > 0 && !res.found; i--) begin
          if (hi_tab[i-1] < v) begin
            res.result_value = hi_tab[i-1];
            res.found = 1'b1;
          end else if (lo_tab[i-1] < v) begin
            res.result_value = v - 32'd1;
            res.found = 1'b1;
          end
        end
      end
      OP_PREVMISS: begin
        if (v != 0) begin
          c = v - 32'd1;
          res.found = 1'b1;
          for (i = n_ranges; i > 0; i--) begin
            if (c >= lo_tab[i-1] && c <= hi_tab[i-1]) begin
              if (lo_tab[i-1] == 0) res.found = 1'b0;
              else c = lo_tab[i-1] - 32'd1;
              break;
            end
          end
          if (res.found) res.result_value = c;
        end
      end
      OP_FIRST: begin
        if (n_ranges > 0) begin
          res.result_value = lo_tab[0];
          res.found = 1'b1;
        end
      end
      default: begin
        if (n_ranges > 0) begin
          res.result_value = hi_tab[n_ranges-1];
          res.found = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  function automatic in_req_t make_req(logic [2:0] op, logic [31:0] v, logic [31:0] e);
    in_req_t r;
    r.op = op;
    r.value = v;
    r.range_end = e;
    return r;
  endfunction

  // values near a small window so ranges collide, with some full-width values
  function automatic logic [31:0] pick_value(logic [31:0] base);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 3);
      default: return base + $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // record each accepted request at the edge that takes it
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(apply_request(in_data));
      void'(pending_reqs.pop_front());
      in_taken = 1'b1;
    end
  end

  // driver: present queued requests, advance on acceptance
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold the stalled request
      end else begin
        if (in_taken) begin
          in_taken = 1'b0;
          send_gap = gap_len();
        end
        if (send_gap > 0 || pause_req || pending_reqs.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_reqs[0];
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int recv_gap = 0;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      recv_gap = gap_len();
      out_stall <= (recv_gap > 0);
    end
  end

  // monitor: check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %p", out_data);
      end else begin
        out_req_t exp_r;
        exp_r = expected_results.pop_front();
        if (out_data.result_value !== exp_r.result_value ||
            out_data.found !== exp_r.found ||
            out_data.table_full !== exp_r.table_full) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected value=%h found=%b full=%b, got value=%h found=%b full=%b",
                     exp_r.result_value, exp_r.found, exp_r.table_full,
                     out_data.result_value, out_data.found, out_data.table_full);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic [31:0] base;
    logic [2:0] op;
    logic [31:0] v;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, merges, splits, overflow
    for (int k = OP_CLEAR; k <= OP_LAST; k++)
      pending_reqs.push_back(make_req(k[2:0], 32'd5, 32'd0));
    pending_reqs.push_back(make_req(OP_INSERT, 32'd9, 32'd3));
    pending_reqs.push_back(make_req(OP_INSERT, 32'd0, 32'd0));
    pending_reqs.push_back(make_req(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_INSERT, 32'd10, 32'd20));
    pending_reqs.push_back(make_req(OP_INSERT, 32'd21, 32'd25));
    pending_reqs.push_back(make_req(OP_INSERT, 32'd2, 32'd9));
    pending_reqs.push_back(make_req(OP_PREVMISS, 32'd15, 32'd0));
    pending_reqs.push_back(make_req(OP_PREVMISS, 32'd0, 32'd0));
    pending_reqs.push_back(make_req(OP_NEXT, 32'hFFFF_FFFF, 32'd0));
    pending_reqs.push_back(make_req(OP_PREV, 32'd0, 32'd0));
    pending_reqs.push_back(make_req(OP_CLEAR, 32'd12, 32'd0));
    pending_reqs.push_back(make_req(OP_CLEAR, 32'hFFFF_FFFF, 32'd0));
    pending_reqs.push_back(make_req(OP_LAST, 32'd0, 32'd0));
    // fill the table with isolated values, then overflow it by insert
    for (int k = 0; k < 16; k++)
      pending_reqs.push_back(make_req(OP_INSERT, 32'h1000 + k * 4, 32'h1001 + k * 4));
    pending_reqs.push_back(make_req(OP_INSERT, 32'h8000_0000, 32'h8000_0000));
    pending_reqs.push_back(make_req(OP_CLEAR, 32'h1000, 32'd0));
    pending_reqs.push_back(make_req(OP_INSERT, 32'h1002, 32'h1004));
    pending_reqs.push_back(make_req(OP_INSERT, 32'h0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_PREVMISS, 32'hFFFF_FFFF, 32'd0));
    pending_reqs.push_back(make_req(OP_CLEAR, 32'h7FFF_FFFF, 32'd0));
    pending_reqs.push_back(make_req(OP_CLEAR, 32'h5555_AAAA, 32'd0));
    wait_drained();

    // random: windows of busy activity, long receiver hold-off once
    base = 32'h100;
    for (int n = 0; n < 1300; n++) begin
      if (n % 200 == 0) base = (n % 400 == 0) ? $urandom() : $urandom_range(0, 512);
      if (n == 400) hold_cycles = 3000;
      if (n == 800) begin
        wait_drained();
        pause_req = 1'b1;
        repeat (50) @(posedge clk);
        pause_req = 1'b0;
      end
      op = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) op = OP_INSERT;
      v = pick_value(base);
      if (op == OP_INSERT)
        pending_reqs.push_back(make_req(op, v,
          ($urandom_range(0, 9) == 0) ? $urandom() : v + $urandom_range(0, 12)));
      else
        pending_reqs.push_back(make_req(op, v, $urandom()));
      while (pending_reqs.size() > 8) @(posedge clk);
    end
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
